### rtl/core/cbb_pkg.sv
// Shared constants, types and arithmetic helpers for the cubic B-spline basis evaluator
`timescale 1ns / 1ps

package cbb_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int X_W       = 17;            // x_point, unsigned Q1.16
  localparam int N_W       = 10;            // node_count
  localparam int I_W       = 11;            // basis_index, also n+1
  localparam int K_W       = 12;            // signed knot offset, -1 .. n+2
  localparam int BX_W      = 27;            // x*(n+1), below 2^27
  localparam int IP_W      = BX_W - FRAC_BITS + 2;  // signed integer part of y
  localparam int Y_W       = IP_W + FRAC_BITS;      // signed scaled argument
  localparam int B_W       = FRAC_BITS + 2; // b = 2-|y|, up to 2.0
  localparam int C_W       = FRAC_BITS + 1; // c = 1-|y|, up to 1.0
  localparam int SQ_W      = FRAC_BITS + 3; // rounded square, up to 4.0
  localparam int CB_W      = FRAC_BITS + 4; // rounded cube, up to 8.0
  localparam int NUM_W     = 24;            // signed numerators and per-term results
  localparam int TOT_W     = NUM_W + 3;     // term sum with weight four
  localparam int OUT_W     = 20;            // signed Q3.16 outputs

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = I_W;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_INDEX = 1'b1;
  localparam logic [N_W-1:0]       NODE_RESET      = 10'd9;
  localparam logic [I_W-1:0]       INDEX_RESET     = 11'd0;

  // Output saturation bounds
  localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sh7FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 20'sh80000;

  // Weight of the second spline term
  typedef enum logic [1:0] {
    WGT_NONE = 2'd0,
    WGT_ONE  = 2'd1,
    WGT_FOUR = 2'd2
  } cbb_wgt_t;

  // Divide by four, rounding half away from zero
  function automatic logic signed [NUM_W-1:0] div4_round(input logic signed [NUM_W-1:0] v);
    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] q;
    mag = v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
    q   = (mag + NUM_W'(2)) >> 2;
    return v[NUM_W-1] ? -signed'(q) : signed'(q);
  endfunction

  // Clamp a term sum to the Q3.16 output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [TOT_W-1:0] v);
    if (v > TOT_W'(OUT_MAX)) begin
      return OUT_MAX;
    end else if (v < TOT_W'(OUT_MIN)) begin
      return OUT_MIN;
    end else begin
      return signed'(v[OUT_W-1:0]);
    end
  endfunction

endpackage

### rtl/core/cbb_if.sv
// Valid/ready channel interfaces for the evaluation points and the basis results
`timescale 1ns / 1ps

interface cbb_in_if;
  logic                      valid;
  logic                      ready;
  logic [cbb_pkg::X_W-1:0]   x_point;

  modport source (output valid, output x_point, input ready);
  modport sink   (input valid, input x_point, output ready);
endinterface

interface cbb_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cbb_pkg::OUT_W-1:0] basis_value;
  logic signed [cbb_pkg::OUT_W-1:0] basis_slope;
  logic                             index_invalid;

  modport source (output valid, output basis_value, output basis_slope,
                  output index_invalid, input ready);
  modport sink   (input valid, input basis_value, input basis_slope,
                  input index_invalid, output ready);
endinterface

### rtl/core/cubic_bspline_basis_eval.sv
// Top level: six-stage pipeline evaluating a cubic B-spline basis value and slope
`timescale 1ns / 1ps
// A transaction passes through the stage registers A..F in order; a stall can hold it in any stage.
// Throughput: one point per cycle while out_item.ready is high; every stage holds one
//   transaction and has its own valid bit, so a stalled output only holds the stages that are full behind it.
// Reset (rst_n, synchronous, active low): clears all valid bits, node_count to 9 and
//   basis_index to 0. Payload registers are not reset.

module cubic_bspline_basis_eval (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbb_pkg::CFG_W-1:0]         cfg_wdata,
  cbb_in_if.sink                            in_item,
  cbb_out_if.source                         out_item
);

  // ---------------------------------------------------------------- configuration
  logic [cbb_pkg::N_W-1:0] node_count_r;
  logic [cbb_pkg::I_W-1:0] basis_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= cbb_pkg::NODE_RESET;
      basis_index_r <= cbb_pkg::INDEX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cbb_pkg::CFG_NODE_COUNT:  node_count_r  <= cfg_wdata[cbb_pkg::N_W-1:0];
        cbb_pkg::CFG_BASIS_INDEX: basis_index_r <= cfg_wdata[cbb_pkg::I_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage valids
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;

  // A stage may load when it is empty or its content moves on
  always_comb begin
    rdy_f = !vf_r || out_item.ready;
    rdy_e = !ve_r || rdy_f;
    rdy_d = !vd_r || rdy_e;
    rdy_c = !vc_r || rdy_d;
    rdy_b = !vb_r || rdy_c;
    rdy_a = !va_r || rdy_b;
  end

  assign in_item.ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_item.valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_e) ve_r <= vd_r;
      if (rdy_f) vf_r <= ve_r;
    end
  end

  // ---------------------------------------------------------------- stage A: decode, scale
  // node_count is 10 bits, so it never exceeds the node limit of 1023
  logic [cbb_pkg::I_W-1:0]          n_plus1;
  logic [cbb_pkg::K_W-1:0]          n_plus2;
  logic signed [cbb_pkg::K_W-1:0]   k_nxt [2];
  cbb_pkg::cbb_wgt_t                wgt_nxt;
  logic                             inv_nxt;
  logic [cbb_pkg::X_W+cbb_pkg::I_W-1:0] prod_x;

  assign n_plus1 = {1'b0, node_count_r} + cbb_pkg::I_W'(1);
  assign n_plus2 = {1'b0, n_plus1} + cbb_pkg::K_W'(1);
  assign prod_x  = in_item.x_point * n_plus1;

  // Pick the knot offsets and the weight of the second term; first match wins
  always_comb begin
    inv_nxt  = 1'b0;
    wgt_nxt  = cbb_pkg::WGT_NONE;
    k_nxt[0] = '0;
    k_nxt[1] = '0;
    if (basis_index_r == cbb_pkg::I_W'(0)) begin
      k_nxt[1] = {cbb_pkg::K_W{1'b1}};  // minus one
      wgt_nxt  = cbb_pkg::WGT_FOUR;
    end else if (basis_index_r == cbb_pkg::I_W'(1)) begin
      k_nxt[0] = cbb_pkg::K_W'(1);
      k_nxt[1] = {cbb_pkg::K_W{1'b1}};
      wgt_nxt  = cbb_pkg::WGT_ONE;
    end else if (basis_index_r < {1'b0, node_count_r}) begin
      k_nxt[0] = signed'({1'b0, basis_index_r});
    end else if (basis_index_r == {1'b0, node_count_r}) begin
      k_nxt[0] = signed'({2'b00, node_count_r});
      k_nxt[1] = signed'(n_plus2);
      wgt_nxt  = cbb_pkg::WGT_ONE;
    end else if (basis_index_r == n_plus1) begin
      k_nxt[0] = signed'({1'b0, n_plus1});
      k_nxt[1] = signed'(n_plus2);
      wgt_nxt  = cbb_pkg::WGT_FOUR;
    end else begin
      inv_nxt  = 1'b1;
    end
  end

  logic [cbb_pkg::BX_W-1:0]         bigx_a_r;
  logic signed [cbb_pkg::K_W-1:0]   k_a_r [2];
  cbb_pkg::cbb_wgt_t                wgt_a_r;
  logic                             inv_a_r;

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      bigx_a_r <= prod_x[cbb_pkg::BX_W-1:0];
      k_a_r[0] <= k_nxt[0];
      k_a_r[1] <= k_nxt[1];
      wgt_a_r  <= wgt_nxt;
      inv_a_r  <= inv_nxt;
    end
  end

  // ---------------------------------------------------------------- stage B: y, b, c
  logic signed [cbb_pkg::IP_W-1:0]  ip    [2];
  logic signed [cbb_pkg::Y_W-1:0]   y     [2];
  logic [cbb_pkg::Y_W-1:0]          u     [2];
  logic [cbb_pkg::B_W-1:0]          b_nxt [2];
  logic [cbb_pkg::C_W-1:0]          c_nxt [2];
  logic                             zero_nxt [2];
  logic                             inner_nxt [2];
  logic                             pos_nxt [2];

  // Subtract the knot from the integer part, then fold to |y|
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      ip[t]        = signed'({2'b00, bigx_a_r[cbb_pkg::BX_W-1:cbb_pkg::FRAC_BITS]})
                     - {k_a_r[t][cbb_pkg::K_W-1], k_a_r[t]};
      y[t]         = {ip[t], bigx_a_r[cbb_pkg::FRAC_BITS-1:0]};
      u[t]         = y[t][cbb_pkg::Y_W-1] ? cbb_pkg::Y_W'(-y[t]) : cbb_pkg::Y_W'(y[t]);
      pos_nxt[t]   = !y[t][cbb_pkg::Y_W-1] && (y[t] != '0);
      zero_nxt[t]  = |u[t][cbb_pkg::Y_W-1:cbb_pkg::FRAC_BITS+1];
      inner_nxt[t] = ~|u[t][cbb_pkg::Y_W-1:cbb_pkg::FRAC_BITS];
      b_nxt[t]     = (cbb_pkg::B_W'(1) << (cbb_pkg::FRAC_BITS + 1))
                     - u[t][cbb_pkg::B_W-1:0];
      c_nxt[t]     = (cbb_pkg::C_W'(1) << cbb_pkg::FRAC_BITS) - u[t][cbb_pkg::C_W-1:0];
    end
  end

  logic [cbb_pkg::B_W-1:0]  b_b_r     [2];
  logic [cbb_pkg::C_W-1:0]  c_b_r     [2];
  logic                     zero_b_r  [2];
  logic                     inner_b_r [2];
  logic                     pos_b_r   [2];
  cbb_pkg::cbb_wgt_t        wgt_b_r;
  logic                     inv_b_r;

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      for (int t = 0; t < 2; t++) begin
        b_b_r[t]     <= b_nxt[t];
        c_b_r[t]     <= c_nxt[t];
        zero_b_r[t]  <= zero_nxt[t];
        inner_b_r[t] <= inner_nxt[t];
        pos_b_r[t]   <= pos_nxt[t];
      end
      wgt_b_r <= wgt_a_r;
      inv_b_r <= inv_a_r;
    end
  end

  // ---------------------------------------------------------------- stage C: squares
  localparam logic [2*cbb_pkg::B_W-1:0] HALF_SQ = (2*cbb_pkg::B_W)'(1) << (cbb_pkg::FRAC_BITS - 1);

  logic [2*cbb_pkg::B_W-1:0] psq_b [2];
  logic [2*cbb_pkg::B_W-1:0] psq_c [2];

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      psq_b[t] = b_b_r[t] * b_b_r[t] + HALF_SQ;
      psq_c[t] = {1'b0, c_b_r[t]} * {1'b0, c_b_r[t]} + HALF_SQ;
    end
  end

  logic [cbb_pkg::SQ_W-1:0] sqb_c_r   [2];
  logic [cbb_pkg::SQ_W-1:0] sqc_c_r   [2];
  logic [cbb_pkg::B_W-1:0]  b_c_r     [2];
  logic [cbb_pkg::C_W-1:0]  c_c_r     [2];
  logic                     zero_c_r  [2];
  logic                     inner_c_r [2];
  logic                     pos_c_r   [2];
  cbb_pkg::cbb_wgt_t        wgt_c_r;
  logic                     inv_c_r;

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      for (int t = 0; t < 2; t++) begin
        sqb_c_r[t]   <= psq_b[t][cbb_pkg::FRAC_BITS+cbb_pkg::SQ_W-1:cbb_pkg::FRAC_BITS];
        sqc_c_r[t]   <= psq_c[t][cbb_pkg::FRAC_BITS+cbb_pkg::SQ_W-1:cbb_pkg::FRAC_BITS];
        b_c_r[t]     <= b_b_r[t];
        c_c_r[t]     <= c_b_r[t];
        zero_c_r[t]  <= zero_b_r[t];
        inner_c_r[t] <= inner_b_r[t];
        pos_c_r[t]   <= pos_b_r[t];
      end
      wgt_c_r <= wgt_b_r;
      inv_c_r <= inv_b_r;
    end
  end

  // ---------------------------------------------------------------- stage D: cubes
  localparam int CP_W = cbb_pkg::SQ_W + cbb_pkg::B_W;
  localparam logic [CP_W-1:0] HALF_CB = CP_W'(1) << (cbb_pkg::FRAC_BITS - 1);

  logic [CP_W-1:0] pcb_b [2];
  logic [CP_W-1:0] pcb_c [2];

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      pcb_b[t] = sqb_c_r[t] * b_c_r[t] + HALF_CB;
      pcb_c[t] = sqc_c_r[t] * {1'b0, c_c_r[t]} + HALF_CB;
    end
  end

  logic [cbb_pkg::CB_W-1:0] cbb_d_r   [2];
  logic [cbb_pkg::CB_W-1:0] cbc_d_r   [2];
  logic [cbb_pkg::SQ_W-1:0] sqb_d_r   [2];
  logic [cbb_pkg::SQ_W-1:0] sqc_d_r   [2];
  logic                     zero_d_r  [2];
  logic                     inner_d_r [2];
  logic                     pos_d_r   [2];
  cbb_pkg::cbb_wgt_t        wgt_d_r;
  logic                     inv_d_r;

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      for (int t = 0; t < 2; t++) begin
        cbb_d_r[t]   <= pcb_b[t][cbb_pkg::FRAC_BITS+cbb_pkg::CB_W-1:cbb_pkg::FRAC_BITS];
        cbc_d_r[t]   <= pcb_c[t][cbb_pkg::FRAC_BITS+cbb_pkg::CB_W-1:cbb_pkg::FRAC_BITS];
        sqb_d_r[t]   <= sqb_c_r[t];
        sqc_d_r[t]   <= sqc_c_r[t];
        zero_d_r[t]  <= zero_c_r[t];
        inner_d_r[t] <= inner_c_r[t];
        pos_d_r[t]   <= pos_c_r[t];
      end
      wgt_d_r <= wgt_c_r;
      inv_d_r <= inv_c_r;
    end
  end

  // ---------------------------------------------------------------- stage E: spline terms
  logic signed [cbb_pkg::NUM_W-1:0] numv    [2];
  logic signed [cbb_pkg::NUM_W-1:0] dsq     [2];
  logic signed [cbb_pkg::NUM_W-1:0] nums    [2];
  logic signed [cbb_pkg::NUM_W-1:0] gmag    [2];
  logic signed [cbb_pkg::NUM_W-1:0] val_nxt [2];
  logic signed [cbb_pkg::NUM_W-1:0] slo_nxt [2];

  // Inner segment subtracts four times the c term; slope carries the factor three
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      numv[t] = signed'(cbb_pkg::NUM_W'(cbb_d_r[t]));
      dsq[t]  = signed'(cbb_pkg::NUM_W'(sqb_d_r[t]));
      if (inner_d_r[t]) begin
        numv[t] = numv[t] - signed'(cbb_pkg::NUM_W'(cbc_d_r[t]) << 2);
        dsq[t]  = dsq[t]  - signed'(cbb_pkg::NUM_W'(sqc_d_r[t]) << 2);
      end
      nums[t] = dsq[t] + (dsq[t] <<< 1);
      gmag[t] = cbb_pkg::div4_round(nums[t]);
      if (zero_d_r[t]) begin
        val_nxt[t] = '0;
        slo_nxt[t] = '0;
      end else begin
        val_nxt[t] = cbb_pkg::div4_round(numv[t]);
        slo_nxt[t] = pos_d_r[t] ? -gmag[t] : gmag[t];
      end
    end
  end

  logic signed [cbb_pkg::NUM_W-1:0] val_e_r [2];
  logic signed [cbb_pkg::NUM_W-1:0] slo_e_r [2];
  cbb_pkg::cbb_wgt_t                wgt_e_r;
  logic                             inv_e_r;

  always_ff @(posedge clk) begin
    if (rdy_e) begin
      for (int t = 0; t < 2; t++) begin
        val_e_r[t] <= val_nxt[t];
        slo_e_r[t] <= slo_nxt[t];
      end
      wgt_e_r <= wgt_d_r;
      inv_e_r <= inv_d_r;
    end
  end

  // ---------------------------------------------------------------- stage F: combine, clamp
  logic signed [cbb_pkg::TOT_W-1:0] wval;
  logic signed [cbb_pkg::TOT_W-1:0] wslo;
  logic signed [cbb_pkg::TOT_W-1:0] tval;
  logic signed [cbb_pkg::TOT_W-1:0] tslo;
  logic signed [cbb_pkg::OUT_W-1:0] value_nxt;
  logic signed [cbb_pkg::OUT_W-1:0] slope_nxt;

  always_comb begin
    case (wgt_e_r)
      cbb_pkg::WGT_ONE: begin
        wval = cbb_pkg::TOT_W'(val_e_r[1]);
        wslo = cbb_pkg::TOT_W'(slo_e_r[1]);
      end
      cbb_pkg::WGT_FOUR: begin
        wval = cbb_pkg::TOT_W'(val_e_r[1]) <<< 2;
        wslo = cbb_pkg::TOT_W'(slo_e_r[1]) <<< 2;
      end
      default: begin
        wval = '0;
        wslo = '0;
      end
    endcase
    tval = cbb_pkg::TOT_W'(val_e_r[0]) - wval;
    tslo = cbb_pkg::TOT_W'(slo_e_r[0]) - wslo;
    // Drop the terms when the index lies beyond n+1
    value_nxt = inv_e_r ? '0 : cbb_pkg::sat_out(tval);
    slope_nxt = inv_e_r ? '0 : cbb_pkg::sat_out(tslo);
  end

  logic signed [cbb_pkg::OUT_W-1:0] value_f_r;
  logic signed [cbb_pkg::OUT_W-1:0] slope_f_r;
  logic                             inv_f_r;

  always_ff @(posedge clk) begin
    if (rdy_f) begin
      value_f_r <= value_nxt;
      slope_f_r <= slope_nxt;
      inv_f_r   <= inv_e_r;
    end
  end

  assign out_item.valid         = vf_r;
  assign out_item.basis_value   = value_f_r;
  assign out_item.basis_slope   = slope_f_r;
  assign out_item.index_invalid = inv_f_r;

  // ---------------------------------------------------------------- assertions
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && out_item.index_invalid |->
      out_item.basis_value == '0 && out_item.basis_slope == '0)
    else $error("invalid index gave non-zero outputs");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_item.valid |-> in_item.ready)
    else $error("input stalled while output register empty");

  a_outside_support: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r && rdy_e && zero_d_r[0] |=> val_e_r[0] == '0 && slo_e_r[0] == '0)
    else $error("spline term non-zero outside its support");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ve_r && rdy_f |=> vf_r)
    else $error("transaction lost between term and output stages");

endmodule

### sim/cubic_bspline_basis_eval_tb.sv
// Self-checking bench for the cubic B-spline basis evaluator: directed table, then random points
`timescale 1ns / 1ps

module cubic_bspline_basis_eval_tb;

  localparam int     CLK_HALF_NS      = 10;
  localparam int     RESET_CYCLES     = 9;
  localparam int     WATCHDOG_LIMIT   = 3000;
  localparam int     LONG_HOLD_CYCLES = 64;
  localparam int     DRAIN_CYCLES     = 12;
  localparam int     SEGMENTS         = 30;
  localparam int     POINTS_PER_SEG   = 15;
  localparam int     PRINT_LIMIT      = 40;
  localparam longint UNIT_Q           = longint'(1) << cbb_pkg::FRAC_BITS;
  localparam longint TWO_Q            = longint'(2) << cbb_pkg::FRAC_BITS;
  localparam longint HALF_Q           = longint'(1) << (cbb_pkg::FRAC_BITS - 1);
  localparam longint X_TOP            = (longint'(1) << cbb_pkg::X_W) - 1;

  typedef struct {
    logic signed [cbb_pkg::OUT_W-1:0] value;
    logic signed [cbb_pkg::OUT_W-1:0] slope;
    logic                             invalid;
  } basis_result_t;

  typedef struct {
    logic [cbb_pkg::N_W-1:0] nodes;
    logic [cbb_pkg::I_W-1:0] index;
    logic [cbb_pkg::X_W-1:0] x;
    bit                      known;
    basis_result_t           want;
  } directed_row_t;

  typedef struct {
    bit            known;
    basis_result_t want;
  } point_tag_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [cbb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cbb_pkg::CFG_W-1:0]     cfg_wdata;

  cbb_in_if  in_item();
  cbb_out_if out_item();

  cubic_bspline_basis_eval uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_item  (out_item)
  );

  directed_row_t            directed_rows[$];
  point_tag_t               point_tags[$];
  basis_result_t            expected_results[$];
  point_tag_t               arrival_tag;
  basis_result_t            oldest;
  logic [cbb_pkg::N_W-1:0]  node_shadow  = cbb_pkg::NODE_RESET;
  logic [cbb_pkg::I_W-1:0]  index_shadow = cbb_pkg::INDEX_RESET;
  int                       mismatch_count   = 0;
  int                       results_checked  = 0;
  int                       points_sent      = 0;
  int                       settings_applied = 0;
  int                       quiet_cycles     = 0;
  int                       tx_idle_pct      = 0;
  int                       rx_idle_pct      = 0;
  int                       hold_left        = 0;
  bit                       long_hold_req    = 1'b0;
  bit                       long_hold_taken  = 1'b0;

  // Clock generation
  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Fixed-point predictor of one basis evaluation
  function automatic longint quarter_round(input longint v);
    if (v >= 0) begin
      return (v + 2) >>> 2;
    end
    return -((-v + 2) >>> 2);
  endfunction

  function automatic longint square_q16(input longint b);
    return (b * b + HALF_Q) >>> cbb_pkg::FRAC_BITS;
  endfunction

  function automatic longint cube_q16(input longint b);
    return (square_q16(b) * b + HALF_Q) >>> cbb_pkg::FRAC_BITS;
  endfunction

  // Value and slope of one shifted spline term at scaled argument y
  function automatic void spline_term(input longint y, output longint val, output longint slope);
    longint mag;
    longint b;
    longint c;
    longint g;
    mag   = (y < 0) ? -y : y;
    val   = 0;
    slope = 0;
    if (mag < TWO_Q) begin
      b = TWO_Q - mag;
      if (mag >= UNIT_Q) begin
        val = quarter_round(cube_q16(b));
        g   = quarter_round(3 * square_q16(b));
      end else begin
        c   = UNIT_Q - mag;
        val = quarter_round(cube_q16(b) - 4 * cube_q16(c));
        g   = quarter_round(3 * (square_q16(b) - 4 * square_q16(c)));
      end
      slope = (y > 0) ? -g : g;
    end
  endfunction

  function automatic logic signed [cbb_pkg::OUT_W-1:0] clamp_q3_16(input longint v);
    if (v > cbb_pkg::OUT_MAX) begin
      return cbb_pkg::OUT_MAX;
    end else if (v < cbb_pkg::OUT_MIN) begin
      return cbb_pkg::OUT_MIN;
    end
    return signed'(v[cbb_pkg::OUT_W-1:0]);
  endfunction

  function automatic basis_result_t predict_basis(input logic [cbb_pkg::N_W-1:0] nodes_reg,
                                                  input logic [cbb_pkg::I_W-1:0] index_reg,
                                                  input logic [cbb_pkg::X_W-1:0] x);
    basis_result_t      r;
    cbb_pkg::cbb_wgt_t  tail;
    longint             n;
    longint             i;
    longint             span;
    longint             k_lead;
    longint             k_tail;
    longint             wt;
    longint             v_lead;
    longint             s_lead;
    longint             v_tail;
    longint             s_tail;
    n         = longint'(nodes_reg);
    i         = longint'(index_reg);
    span      = longint'(x) * (n + 1);
    r.value   = '0;
    r.slope   = '0;
    r.invalid = 1'b0;
    tail      = cbb_pkg::WGT_NONE;
    k_lead    = 0;
    k_tail    = 0;
    // Pick the combination; the first matching test wins
    if (i == 0) begin
      k_tail = -1;
      tail   = cbb_pkg::WGT_FOUR;
    end else if (i == 1) begin
      k_lead = 1;
      k_tail = -1;
      tail   = cbb_pkg::WGT_ONE;
    end else if (i >= 2 && i <= n - 1) begin
      k_lead = i;
    end else if (i == n) begin
      k_lead = n;
      k_tail = n + 2;
      tail   = cbb_pkg::WGT_ONE;
    end else if (i == n + 1) begin
      k_lead = n + 1;
      k_tail = n + 2;
      tail   = cbb_pkg::WGT_FOUR;
    end else begin
      r.invalid = 1'b1;
    end
    if (!r.invalid) begin
      spline_term(span - k_lead * UNIT_Q, v_lead, s_lead);
      spline_term(span - k_tail * UNIT_Q, v_tail, s_tail);
      wt      = (tail == cbb_pkg::WGT_FOUR) ? 4 : ((tail == cbb_pkg::WGT_ONE) ? 1 : 0);
      r.value = clamp_q3_16(v_lead - wt * v_tail);
      r.slope = clamp_q3_16(s_lead - wt * s_tail);
    end
    return r;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("mismatch on %s at result %0d: got %0d, expected %0d", what, results_checked,
               got, want);
    end
    mismatch_count++;
  endtask

  task automatic add_row(input int nodes, input int index, input int x, input bit known,
                         input int v, input int s, input bit inv);
    directed_row_t row;
    row.nodes         = cbb_pkg::N_W'(nodes);
    row.index         = cbb_pkg::I_W'(index);
    row.x             = cbb_pkg::X_W'(x);
    row.known         = known;
    row.want.value    = cbb_pkg::OUT_W'(v);
    row.want.slope    = cbb_pkg::OUT_W'(s);
    row.want.invalid  = inv;
    directed_rows.push_back(row);
  endtask

  // Offer one point, with random gaps ahead of it, and hold until the transaction
  task automatic send_point(input logic [cbb_pkg::X_W-1:0] x, input bit known,
                            input basis_result_t want);
    point_tag_t tag;
    tag.known = known;
    tag.want  = want;
    point_tags.push_back(tag);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid   <= 1'b1;
    in_item.x_point <= x;
    @(posedge clk);
    while (!in_item.ready) @(posedge clk);
    points_sent++;
  endtask

  // Drain the pipeline, then write both registers
  task automatic apply_setting(input logic [cbb_pkg::N_W-1:0] nodes,
                               input logic [cbb_pkg::I_W-1:0] index);
    in_item.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= cbb_pkg::CFG_NODE_COUNT;
    cfg_wdata <= cbb_pkg::CFG_W'(nodes);
    @(posedge clk);
    cfg_index <= cbb_pkg::CFG_BASIS_INDEX;
    cfg_wdata <= index;
    @(posedge clk);
    cfg_we       <= 1'b0;
    node_shadow  = nodes;
    index_shadow = index;
    settings_applied++;
  endtask

  // Result-side ready: random stalls plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_item.ready <= 1'b0;
      hold_left      = 0;
    end else begin
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        hold_left       = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_item.ready <= 1'b0;
      end else begin
        out_item.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Predict on every input transaction, check every output transaction, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (in_item.valid && in_item.ready) begin
        quiet_cycles = 0;
        arrival_tag.known = 1'b0;
        if (point_tags.size() != 0) begin
          arrival_tag = point_tags.pop_front();
        end
        if (arrival_tag.known) begin
          expected_results.push_back(arrival_tag.want);
        end else begin
          expected_results.push_back(predict_basis(node_shadow, index_shadow,
                                                   in_item.x_point));
        end
      end
      if (out_item.valid && out_item.ready) begin
        quiet_cycles = 0;
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 1, 0);
        end else begin
          oldest = expected_results.pop_front();
          if (out_item.basis_value !== oldest.value) begin
            report_mismatch("basis_value", longint'(out_item.basis_value),
                            longint'(oldest.value));
          end
          if (out_item.basis_slope !== oldest.slope) begin
            report_mismatch("basis_slope", longint'(out_item.basis_slope),
                            longint'(oldest.slope));
          end
          if (out_item.index_invalid !== oldest.invalid) begin
            report_mismatch("index_invalid", longint'(out_item.index_invalid),
                            longint'(oldest.invalid));
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Main stimulus
  initial begin : stimulus
    directed_row_t            row;
    basis_result_t            no_want;
    logic [cbb_pkg::N_W-1:0]  seg_nodes;
    logic [cbb_pkg::I_W-1:0]  seg_index;
    logic [cbb_pkg::X_W-1:0]  pt;
    longint                   num;
    longint                   idx;
    int                       seg;
    int                       k;
    int                       sel;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= cbb_pkg::CFG_NODE_COUNT;
    cfg_wdata       <= '0;
    in_item.valid   <= 1'b0;
    in_item.x_point <= '0;
    rx_idle_pct     <= 79;
    tx_idle_pct     = 34;
    no_want.value   = '0;
    no_want.slope   = '0;
    no_want.invalid = 1'b0;

    // Directed table: nodes, index, point, typed flag, value, slope, invalid
    add_row(9,    0,    0,      1, 0,     196608, 0);  // reset setting, left end
    add_row(9,    0,    65536,  0, 0,     0,      0);
    add_row(9,    0,    131071, 0, 0,     0,      0);  // largest point
    add_row(9,    1,    0,      0, 0,     0,      0);
    add_row(9,    1,    7282,   0, 0,     0,      0);
    add_row(9,    5,    0,      1, 0,     0,      0);  // far outside support
    add_row(9,    5,    32768,  1, 65536, 0,      0);  // spline centre
    add_row(9,    5,    65536,  1, 0,     0,      0);
    add_row(9,    9,    65536,  0, 0,     0,      0);  // index n
    add_row(9,    10,   65536,  0, 0,     0,      0);  // index n+1
    add_row(9,    11,   30000,  1, 0,     0,      1);  // index just out of range
    add_row(9,    1024, 1,      1, 0,     0,      1);  // largest index
    add_row(0,    0,    0,      0, 0,     0,      0);  // zero nodes
    add_row(0,    1,    65536,  0, 0,     0,      0);
    add_row(0,    2,    100,    1, 0,     0,      1);
    add_row(1,    1,    32768,  0, 0,     0,      0);  // single node, index one
    add_row(1,    2,    65536,  0, 0,     0,      0);
    add_row(1,    3,    0,      1, 0,     0,      1);
    add_row(1023, 1024, 65536,  0, 0,     0,      0);
    add_row(1023, 1023, 131071, 0, 0,     0,      0);
    add_row(1023, 512,  32768,  1, 65536, 0,      0);
    add_row(1023, 2,    131071, 0, 0,     0,      0);
    add_row(2,    1,    21845,  0, 0,     0,      0);
    add_row(2,    2,    43690,  0, 0,     0,      0);
    add_row(3,    2,    43690,  0, 0,     0,      0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table, rewriting the registers when a row asks for a new setting
    for (k = 0; k < directed_rows.size(); k++) begin
      row = directed_rows[k];
      if (row.nodes != node_shadow || row.index != index_shadow) begin
        apply_setting(row.nodes, row.index);
      end
      send_point(row.x, row.known, row.want);
    end

    // Random segments: one register setting each, idle pattern changing every ten
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 10)
        0: begin
          seg_nodes = cbb_pkg::N_W'(1023);
        end
        1: begin
          seg_nodes = cbb_pkg::N_W'(1);
        end
        2: begin
          seg_nodes = '0;
        end
        3: begin
          seg_nodes = cbb_pkg::N_W'(2);
        end
        default: begin
          sel = $urandom_range(2);
          if (sel == 0) begin
            seg_nodes = cbb_pkg::N_W'($urandom_range(3, 20));
          end else if (sel == 1) begin
            seg_nodes = cbb_pkg::N_W'($urandom_range(21, 1023));
          end else begin
            seg_nodes = cbb_pkg::N_W'(9);
          end
        end
      endcase
      case ($urandom_range(8))
        0: idx = 0;
        1: idx = 1;
        2: idx = longint'(seg_nodes);
        3: idx = longint'(seg_nodes) + 1;
        4: idx = longint'(seg_nodes) + 2;
        5: idx = 1024;
        6: idx = longint'($urandom_range(1024));
        default: begin
          if (seg_nodes >= 3) begin
            idx = longint'($urandom_range(2, seg_nodes - 1));
          end else begin
            idx = longint'(seg_nodes) + 1;
          end
        end
      endcase
      if (idx > 1024) begin
        idx = 1024;
      end
      seg_index = idx[cbb_pkg::I_W-1:0];
      apply_setting(seg_nodes, seg_index);

      if (seg == SEGMENTS / 3) begin
        tx_idle_pct = 79;
        rx_idle_pct <= 34;
      end else if (seg == 2 * SEGMENTS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        // Hold the output off while points keep coming, so the pipeline backs up
        long_hold_req <= 1'b1;
      end

      for (k = 0; k < POINTS_PER_SEG; k++) begin
        sel = $urandom_range(9);
        if (sel == 0) begin
          pt = cbb_pkg::X_W'($urandom_range(0, int'(X_TOP)));
        end else if (sel == 1) begin
          case ($urandom_range(3))
            0: pt = '0;
            1: pt = cbb_pkg::X_W'(65536);
            2: pt = cbb_pkg::X_W'(X_TOP);
            default: pt = cbb_pkg::X_W'(65535);
          endcase
        end else begin
          // Aim near the support of the chosen basis, reflecting off the left end
          num = longint'(seg_index) * UNIT_Q + longint'($urandom_range(0, 6 * 65536))
                - 3 * UNIT_Q;
          if (num < 0) begin
            num = -num;
          end
          num = num / (longint'(seg_nodes) + 1);
          if (num > X_TOP) begin
            num = X_TOP;
          end
          pt = num[cbb_pkg::X_W-1:0];
        end
        send_point(pt, 1'b0, no_want);
      end
    end

    // Drain and let the pipeline settle
    in_item.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d points (%0d from the table) over %0d settings.",
             results_checked, points_sent, directed_rows.size(), settings_applied);
    $display("Covered node counts 0, 1, 2 and 1023, edge and out-of-range indexes, long hold.");
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
